>>> rtl/tsbs_pkg.sv
// Package for the texel store / bilinear sampler.
// Request and format codes, register indexes, texel decode and encode helpers.
// No dependencies.
`timescale 1ns / 1ps

package tsbs_pkg;

  localparam int unsigned TEXEL_COUNT_DEF = 4096;

  typedef enum logic [1:0] {
    REQ_WRITE    = 2'd0,
    REQ_NEAREST  = 2'd1,
    REQ_BILINEAR = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    FMT_RGB  = 2'd0,
    FMT_BGR  = 2'd1,
    FMT_RGBA = 2'd2,
    FMT_LUM  = 2'd3
  } fmt_t;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_DEPTH  = 2'd2,
    CFG_FORMAT = 2'd3
  } cfg_idx_t;

  // channel bytes: [0] red, [1] green, [2] blue, [3] alpha
  typedef logic [3:0][7:0] texel_t;

  // round(avg(r,g,b)) = (2*(r+g+b)+3)/6; /6 as multiply by 1366 >> 13,
  // exact for numerators below 1534
  function automatic logic [7:0] lum_avg(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    logic [10:0] n;
    logic [21:0] p;
    n = 11'({r, 1'b0}) + 11'({g, 1'b0}) + 11'({b, 1'b0}) + 11'd3;
    p = 22'(n) * 22'd1366;
    return p[20:13];
  endfunction

  function automatic logic [31:0] encode(input fmt_t fmt, input texel_t t);
    logic [31:0] e;
    unique case (fmt)
      FMT_RGB:  e = {8'h00, t[2], t[1], t[0]};
      FMT_BGR:  e = {8'h00, t[0], t[1], t[2]};
      FMT_RGBA: e = {t[3], t[2], t[1], t[0]};
      FMT_LUM:  e = {24'h000000, lum_avg(t[0], t[1], t[2])};
    endcase
    return e;
  endfunction

  function automatic texel_t decode(input fmt_t fmt, input logic [31:0] e);
    texel_t t;
    unique case (fmt)
      FMT_RGB:  t = {8'hFF, e[23:16], e[15:8], e[7:0]};
      FMT_BGR:  t = {8'hFF, e[7:0], e[15:8], e[23:16]};
      FMT_RGBA: t = e;
      FMT_LUM:  t = {8'hFF, e[7:0], e[7:0], e[7:0]};
    endcase
    return t;
  endfunction

endpackage

>>> rtl/tsbs_ram.sv
// Generic single-port RAM, one read or write per cycle, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tsbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

>>> rtl/texel_store_bilinear_sampler_unit.sv
// Texel store with wrap-addressed nearest / bilinear sampler, top level.
// Depends on tsbs_pkg and tsbs_ram.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; exactly one result
// word follows, shown for one cycle with out_valid, and the receiver cannot
// stall it. After reset the block clears every entry of the texel store, one
// entry a cycle, with busy high; configuration writes are taken anyway.
// Everything goes through one single-port store, one request at a time: a
// write (or unused code) passes MUL1, MUL2 and ADDR, a nearest sample adds one
// store read and an output state, a bilinear sample four store reads back to
// back, then two blend stages. Sizes of zero act as one. Sample addresses
// past the store read as all-zero texels.
module texel_store_bilinear_sampler_unit #(
  parameter int unsigned TEXEL_COUNT = tsbs_pkg::TEXEL_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request word
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [11:0] in_texel_index,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  input  logic [15:0] in_pos_u,
  input  logic [15:0] in_pos_v,
  input  logic [15:0] in_pos_w,
  // result word
  output logic        out_valid,
  output logic [15:0] out_red,
  output logic [15:0] out_green,
  output logic [15:0] out_blue,
  output logic [15:0] out_alpha,
  output logic        out_status,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int unsigned AW = $clog2(TEXEL_COUNT);
  localparam logic [31:0] COUNT32 = 32'(TEXEL_COUNT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TEXEL_COUNT - 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MUL1, ST_MUL2, ST_ADDR, ST_READ, ST_NOUT, ST_BL1, ST_BL2
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [12:0]       cfg_w_r, cfg_h_r;
  logic [2:0]        cfg_d_r;
  tsbs_pkg::fmt_t    fmt_r;

  // effective sizes, zero reads as one
  logic [12:0] w_eff, h_eff;
  logic [2:0]  d_eff;
  assign w_eff = (cfg_w_r == '0) ? 13'd1 : cfg_w_r;
  assign h_eff = (cfg_h_r == '0) ? 13'd1 : cfg_h_r;
  assign d_eff = (cfg_d_r == '0) ? 3'd1 : cfg_d_r;

  // latched request
  tsbs_pkg::req_t  req_r;
  logic [11:0]     idx_r;
  tsbs_pkg::texel_t wtex_r;
  logic [15:0]     u_r, v_r, w_r;

  // address pipeline
  logic [28:0] ux_r, vy_r;
  logic [18:0] wz_r;
  logic [25:0] wh_r, row0_r;
  logic [28:0] base_r, whd_r;
  logic [12:0] x0_r, x1_r, y0_w_r;
  logic        y1z_r;
  logic [15:0] fx_r, fy_r;
  logic [3:0][29:0] addr_r;
  logic [3:0]       oob_r;

  // reads and blend
  logic [2:0]            rcnt_r;
  logic [2:0]            nrd_r;
  tsbs_pkg::texel_t [3:0] tex_r;   // slots: 00, 10, 01, 11
  logic [3:0][23:0]      top_r, bot_r;

  logic [AW-1:0] clr_r;

  logic        out_valid_r, status_r;
  logic [3:0][15:0] out_ch_r;

  // store port
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata, mem_rdata;
  logic [31:0]   idx_ext;
  logic          wr_oob;

  assign idx_ext = 32'(idx_r);
  assign wr_oob  = (29'(idx_r) >= whd_r) || (idx_ext >= COUNT32);

  tsbs_ram #(.WIDTH(32), .DEPTH(TEXEL_COUNT)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = addr_r[rcnt_r[1:0]][AW-1:0];
    mem_wdata = tsbs_pkg::encode(fmt_r, wtex_r);
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_addr  = clr_r;
      mem_wdata = '0;
    end else if (state_r == ST_ADDR) begin
      mem_addr = idx_ext[AW-1:0];
      mem_we   = (req_r == tsbs_pkg::REQ_WRITE) && !wr_oob;
    end
  end

  // wrap math: t = u*W - 1/2 texel; floor(t) of -1 wraps to W-1
  logic [29:0] tu, tv;
  logic [13:0] xp1, yp1;
  logic [12:0] x0_c, x1_c, y0_c, y1_c;
  logic        bil;

  always_comb begin
    bil = (req_r == tsbs_pkg::REQ_BILINEAR);
    tu  = {1'b0, ux_r} - 30'd32768;
    tv  = {1'b0, vy_r} - 30'd32768;
    xp1 = {1'b0, tu[28:16]} + 14'd1;
    yp1 = {1'b0, tv[28:16]} + 14'd1;
    if (!bil) begin
      x0_c = ux_r[28:16];
      y0_c = vy_r[28:16];
      x1_c = x0_c;
      y1_c = y0_c;
    end else begin
      x0_c = tu[29] ? w_eff - 13'd1 : tu[28:16];
      y0_c = tv[29] ? h_eff - 13'd1 : tv[28:16];
      x1_c = (tu[29] || xp1 == {1'b0, w_eff}) ? 13'd0 : xp1[12:0];
      y1_c = (tv[29] || yp1 == {1'b0, h_eff}) ? 13'd0 : yp1[12:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == LAST_ADDR) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_ADDR;
      ST_ADDR: begin
        if (req_r == tsbs_pkg::REQ_NEAREST || req_r == tsbs_pkg::REQ_BILINEAR) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        if (rcnt_r == nrd_r) state_nxt = bil ? ST_BL1 : ST_NOUT;
      end
      ST_NOUT:  state_nxt = ST_IDLE;
      ST_BL1:   state_nxt = ST_BL2;
      ST_BL2:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // blend stage 2 lanes
  logic [3:0][40:0] acc_c;
  logic [16:0]      wfy0, wfy1, wfx0, wfx1;
  assign wfx1 = {1'b0, fx_r};
  assign wfx0 = 17'h10000 - wfx1;
  assign wfy1 = {1'b0, fy_r};
  assign wfy0 = 17'h10000 - wfy1;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      acc_c[k] = 41'(top_r[k]) * 41'(wfy0) + 41'(bot_r[k]) * 41'(wfy1) + 41'h800000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cfg_w_r     <= 13'd1;
      cfg_h_r     <= 13'd1;
      cfg_d_r     <= 3'd1;
      fmt_r       <= tsbs_pkg::FMT_RGB;
      out_valid_r <= 1'b0;
      rcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;

      if (cfg_valid) begin
        unique case (tsbs_pkg::cfg_idx_t'(cfg_index))
          tsbs_pkg::CFG_WIDTH:  cfg_w_r <= cfg_data;
          tsbs_pkg::CFG_HEIGHT: cfg_h_r <= cfg_data;
          tsbs_pkg::CFG_DEPTH:  cfg_d_r <= cfg_data[2:0];
          tsbs_pkg::CFG_FORMAT: fmt_r   <= tsbs_pkg::fmt_t'(cfg_data[1:0]);
        endcase
      end

      unique case (state_r)
        ST_CLEAR: clr_r <= clr_r + 1'b1;
        ST_IDLE: begin
          if (start) begin
            req_r  <= tsbs_pkg::req_t'(in_req_type);
            idx_r  <= in_texel_index;
            wtex_r <= {in_alpha, in_blue, in_green, in_red};
            u_r    <= in_pos_u;
            v_r    <= in_pos_v;
            w_r    <= in_pos_w;
          end
        end
        ST_MUL1: begin
          ux_r <= 29'(u_r) * 29'(w_eff);
          vy_r <= 29'(v_r) * 29'(h_eff);
          wz_r <= 19'(w_r) * 19'(d_eff);
          wh_r <= 26'(w_eff) * 26'(h_eff);
        end
        ST_MUL2: begin
          x0_r   <= x0_c;
          x1_r   <= x1_c;
          y0_w_r <= w_eff;
          y1z_r  <= (y1_c == '0);
          fx_r   <= tu[15:0];
          fy_r   <= tv[15:0];
          row0_r <= 26'(y0_c) * 26'(w_eff);
          base_r <= 29'(wz_r[18:16]) * 29'(wh_r);
          whd_r  <= 29'(wh_r) * 29'(d_eff);
        end
        ST_ADDR: begin
          logic [29:0] row1;
          row1 = y1z_r ? 30'd0 : 30'(row0_r) + 30'(y0_w_r);
          addr_r[0] <= 30'(base_r) + 30'(row0_r) + 30'(x0_r);
          addr_r[1] <= 30'(base_r) + 30'(row0_r) + 30'(x1_r);
          addr_r[2] <= 30'(base_r) + row1 + 30'(x0_r);
          addr_r[3] <= 30'(base_r) + row1 + 30'(x1_r);
          nrd_r     <= bil ? 3'd4 : 3'd1;
          rcnt_r    <= '0;
          if (req_r == tsbs_pkg::REQ_WRITE || req_r == tsbs_pkg::REQ_NONE) begin
            out_valid_r <= 1'b1;
            out_ch_r    <= '0;
            status_r    <= (req_r == tsbs_pkg::REQ_WRITE) && wr_oob;
          end
        end
        ST_READ: begin
          // issue slot rcnt, capture slot rcnt-1
          if (rcnt_r < 3'd4) begin
            oob_r[rcnt_r[1:0]] <= (32'(addr_r[rcnt_r[1:0]]) >= COUNT32);
          end
          if (rcnt_r != '0) begin
            tex_r[2'(rcnt_r - 3'd1)] <= oob_r[2'(rcnt_r - 3'd1)] ? '0 :
                                        tsbs_pkg::decode(fmt_r, mem_rdata);
          end
          rcnt_r <= rcnt_r + 3'd1;
        end
        ST_NOUT: begin
          out_valid_r <= 1'b1;
          status_r    <= 1'b0;
          for (int k = 0; k < 4; k++) out_ch_r[k] <= {tex_r[0][k], 8'h00};
        end
        ST_BL1: begin
          for (int k = 0; k < 4; k++) begin
            top_r[k] <= 24'(25'(tex_r[0][k]) * 25'(wfx0) + 25'(tex_r[1][k]) * 25'(wfx1));
            bot_r[k] <= 24'(25'(tex_r[2][k]) * 25'(wfx0) + 25'(tex_r[3][k]) * 25'(wfx1));
          end
        end
        ST_BL2: begin
          out_valid_r <= 1'b1;
          status_r    <= 1'b0;
          for (int k = 0; k < 4; k++) out_ch_r[k] <= acc_c[k][39:24];
        end
        default: ;
      endcase
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_red    = out_ch_r[0];
  assign out_green  = out_ch_r[1];
  assign out_blue   = out_ch_r[2];
  assign out_alpha  = out_ch_r[3];
  assign out_status = status_r;

`ifndef SYNTH
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r != ST_IDLE) && $past(state_r != ST_CLEAR))
    else $error("result without a request in flight");

  a_no_result_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid_r)
    else $error("result strobe right after accept");

  a_status_zero_channels: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r) |-> (out_ch_r == '0))
    else $error("rejected write returned channel data");

  a_clear_no_write_req: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> mem_we && busy)
    else $error("clearing pass not writing");
`endif

endmodule
